FILE: design/smsp_pkg.sv
// Package: codes, parser state type and permission letter decode for the mode string parser.
`timescale 1ns / 1ps

package smsp_pkg;

    localparam int ModeWidth = 12;
    localparam int CharWidth = 8;

    localparam logic [CharWidth-1:0] CHAR_COMMA  = 8'h2C;
    localparam logic [CharWidth-1:0] CHAR_PLUS   = 8'h2B;
    localparam logic [CharWidth-1:0] CHAR_EQUALS = 8'h3D;
    localparam logic [CharWidth-1:0] CHAR_U      = 8'h75;
    localparam logic [CharWidth-1:0] CHAR_G      = 8'h67;
    localparam logic [CharWidth-1:0] CHAR_O      = 8'h6F;
    localparam logic [CharWidth-1:0] CHAR_R      = 8'h72;
    localparam logic [CharWidth-1:0] CHAR_W      = 8'h77;
    localparam logic [CharWidth-1:0] CHAR_X      = 8'h78;
    localparam logic [CharWidth-1:0] CHAR_S      = 8'h73;
    localparam logic [CharWidth-1:0] CHAR_T      = 8'h74;

    localparam logic [ModeWidth-1:0] MODE_SETUID = 12'o4000;
    localparam logic [ModeWidth-1:0] MODE_SETGID = 12'o2000;
    localparam logic [ModeWidth-1:0] MODE_STICKY = 12'o1000;

    typedef enum logic [1:0] {
        POS_START    = 2'd0,
        POS_OWNER    = 2'd1,
        POS_LETTERS  = 2'd2,
        POS_BADOWNER = 2'd3
    } pos_t;

    typedef enum logic [1:0] {
        OWN_USER  = 2'd0,
        OWN_GROUP = 2'd1,
        OWN_OTHER = 2'd2,
        OWN_PLUS  = 2'd3
    } owner_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_MALFORMED  = 2'd1,
        ERR_PERMISSION = 2'd2,
        ERR_OWNER      = 2'd3
    } err_t;

    typedef struct packed {
        pos_t                 pos;
        owner_t               owner;
        err_t                 err;
        logic [ModeWidth-1:0] mode;
    } parse_state_t;

    localparam parse_state_t PARSE_RESET = '{
        pos:   POS_START,
        owner: OWN_USER,
        err:   ERR_NONE,
        mode:  '0
    };

    typedef struct packed {
        logic                 emit;
        err_t                 err;
        logic [ModeWidth-1:0] mode;
    } parse_result_t;

    // Mode bit for one letter under an owner; zero means not allowed.
    function automatic logic [ModeWidth-1:0] letter_bit(
        input owner_t               owner,
        input logic [CharWidth-1:0] c
    );
        logic [3:0]           shift;
        logic [ModeWidth-1:0] bit_val;
        begin
            shift   = (owner == OWN_USER)  ? 4'd6 :
                      (owner == OWN_GROUP) ? 4'd3 : 4'd0;
            bit_val = '0;
            if (owner == OWN_PLUS)
            begin
                bit_val = (c == CHAR_T) ? MODE_STICKY : '0;
            end
            else
            begin
                case (c)
                    CHAR_R:  bit_val = ModeWidth'(4) << shift;
                    CHAR_W:  bit_val = ModeWidth'(2) << shift;
                    CHAR_X:  bit_val = ModeWidth'(1) << shift;
                    CHAR_S:  bit_val = (owner == OWN_USER)  ? MODE_SETUID :
                                       (owner == OWN_GROUP) ? MODE_SETGID : '0;
                    default: bit_val = '0;
                endcase
            end
            return bit_val;
        end
    endfunction

endpackage

FILE: design/smsp_char_if.sv
// Interface: character item channel with valid/ready handshake.
`timescale 1ns / 1ps

interface smsp_char_if;
    logic                           valid;
    logic                           ready;
    logic [smsp_pkg::CharWidth-1:0] char_code;
    logic                           end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

FILE: design/smsp_mode_if.sv
// Interface: mode result item channel with valid/ready handshake.
`timescale 1ns / 1ps

interface smsp_mode_if;
    logic                           valid;
    logic                           ready;
    logic [smsp_pkg::ModeWidth-1:0] mode_bits;
    logic [1:0]                     error_code;

    modport source (output valid, output mode_bits, output error_code, input ready);
    modport sink   (input valid, input mode_bits, input error_code, output ready);
endinterface

FILE: design/smsp_char_step.sv
// Module: per-character clause decode, next parser state and string result.
`timescale 1ns / 1ps

module smsp_char_step (
    input  smsp_pkg::parse_state_t           cur,
    input  logic [smsp_pkg::CharWidth-1:0]   char_code,
    input  logic                             end_of_string,
    output smsp_pkg::parse_state_t           next,
    output smsp_pkg::parse_result_t          result
);
    import smsp_pkg::*;

    parse_state_t             taken;
    logic [ModeWidth-1:0]     bit_val;
    err_t                     final_err;

    assign bit_val = letter_bit(cur.owner, char_code);

    // Next: take one character unless an error is held; the last one resets.
    always_comb
    begin
        taken = cur;
        if (cur.err == ERR_NONE)
        begin
            unique case (cur.pos)
                POS_START:
                begin
                    if (char_code == CHAR_COMMA)
                    begin
                        taken.pos = POS_START;
                    end
                    else if (char_code == CHAR_U)
                    begin
                        taken.owner = OWN_USER;
                        taken.pos   = POS_OWNER;
                    end
                    else if (char_code == CHAR_G)
                    begin
                        taken.owner = OWN_GROUP;
                        taken.pos   = POS_OWNER;
                    end
                    else if (char_code == CHAR_O)
                    begin
                        taken.owner = OWN_OTHER;
                        taken.pos   = POS_OWNER;
                    end
                    else if (char_code == CHAR_PLUS)
                    begin
                        taken.owner = OWN_PLUS;
                        taken.pos   = POS_OWNER;
                    end
                    else
                    begin
                        taken.pos = POS_BADOWNER;
                    end
                end
                POS_OWNER:
                begin
                    if (char_code == CHAR_COMMA)
                    begin
                        taken.err = ERR_MALFORMED;
                    end
                    else if (cur.owner == OWN_PLUS)
                    begin
                        if (bit_val == '0)
                        begin
                            taken.err = ERR_PERMISSION;
                        end
                        else
                        begin
                            taken.mode = cur.mode | bit_val;
                            taken.pos  = POS_LETTERS;
                        end
                    end
                    else if (char_code == CHAR_EQUALS)
                    begin
                        taken.pos = POS_LETTERS;
                    end
                    else
                    begin
                        taken.err = ERR_MALFORMED;
                    end
                end
                POS_LETTERS:
                begin
                    if (char_code == CHAR_COMMA)
                    begin
                        taken.pos = POS_START;
                    end
                    else if (bit_val == '0)
                    begin
                        taken.err = ERR_PERMISSION;
                    end
                    else
                    begin
                        taken.mode = cur.mode | bit_val;
                    end
                end
                POS_BADOWNER:
                begin
                    taken.err = (char_code == CHAR_EQUALS) ? ERR_OWNER : ERR_MALFORMED;
                end
                default:
                begin
                    taken.err = ERR_MALFORMED;
                end
            endcase
        end
        next = end_of_string ? PARSE_RESET : taken;
    end

    // Output: close the string on its last character.
    always_comb
    begin
        final_err = taken.err;
        if (taken.err == ERR_NONE &&
            (taken.pos == POS_OWNER || taken.pos == POS_BADOWNER))
        begin
            final_err = ERR_MALFORMED;
        end
        result.emit = end_of_string;
        result.err  = final_err;
        result.mode = (final_err == ERR_NONE) ? taken.mode : '0;
    end

endmodule

FILE: design/symbolic_mode_string_parser.sv
// Top level: symbolic mode string parser with registered input and result stages.
// Order: a last character is taken into the input register, then its result into the result register.
// Throughput: one character item per cycle while the result is not stalled.
// Back pressure: the input register and result register stall together when the result waits.
// Reset: rst_n clears both stage valids and the parser state to clause start, no error.
`timescale 1ns / 1ps

module symbolic_mode_string_parser (
    input  logic        clk,
    input  logic        rst_n,
    smsp_char_if.sink   char_in,
    smsp_mode_if.source mode_out
);
    import smsp_pkg::*;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [CharWidth-1:0] in_char_reg;
    logic                 in_eos_reg;

    parse_state_t         state_reg;
    parse_state_t         state_next;
    parse_result_t        step_result;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [ModeWidth-1:0] out_mode_reg;
    err_t                 out_err_reg;

    logic                 advance;
    logic                 proc;
    logic                 in_fire;

    assign advance       = !out_valid_reg || mode_out.ready;
    assign proc          = in_valid_reg && advance;
    assign char_in.ready = !in_valid_reg || advance;
    assign in_fire       = char_in.valid && char_in.ready;

    assign in_valid_next  = in_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance ? (proc && step_result.emit) : out_valid_reg;

    smsp_char_step u_step (
        .cur           (state_reg),
        .char_code     (in_char_reg),
        .end_of_string (in_eos_reg),
        .next          (state_next),
        .result        (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PARSE_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_char_reg <= char_in.char_code;
            in_eos_reg  <= char_in.end_of_string;
        end
        if (proc && step_result.emit)
        begin
            out_mode_reg <= step_result.mode;
            out_err_reg  <= step_result.err;
        end
    end

    assign mode_out.valid      = out_valid_reg;
    assign mode_out.mode_bits  = out_mode_reg;
    assign mode_out.error_code = out_err_reg;

    a_mode_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg != ERR_NONE |-> out_mode_reg == '0)
        else $error("mode bits nonzero on an error result");

    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_eos_reg |=> state_reg == PARSE_RESET)
        else $error("parser state not cleared after last character");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.err != ERR_NONE && !(proc && in_eos_reg) |=>
        state_reg.err == $past(state_reg.err))
        else $error("held error changed within a string");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(proc && in_eos_reg))
        else $error("result item without a last character");

endmodule

FILE: bench/symbolic_mode_string_parser_tb.sv
// Testbench: mode strings sent under random idling and stalls, checked against a local parse.
`timescale 1ns / 1ps

module symbolic_mode_string_parser_tb;

    import smsp_pkg::*;

    localparam int CycleLimit   = 200000;
    localparam int RandomChars  = 600;
    localparam int ReportLimit  = 10;

    typedef logic [CharWidth-1:0] char_q_t[$];

    typedef struct packed {
        logic [ModeWidth-1:0] mode;
        err_t                 err;
    } mode_result_t;

    logic clk;
    logic rst_n;

    smsp_char_if chr ();
    smsp_mode_if res ();

    symbolic_mode_string_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (chr),
        .mode_out (res)
    );

    pos_t                 pred_pos;
    owner_t               pred_owner;
    err_t                 pred_err;
    logic [ModeWidth-1:0] pred_mode;

    mode_result_t expected_modes[$];
    mode_result_t oldest;

    int fail_count    = 0;
    int cycle_count   = 0;
    int burst_left    = 0;
    int chars_sent    = 0;
    int strings_sent  = 0;
    int results_seen  = 0;
    int err_tally[4]  = '{0, 0, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_modes.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [ModeWidth-1:0] perm_bit(input owner_t who,
                                                      input logic [CharWidth-1:0] c);
        logic [ModeWidth-1:0] grant;
        grant = '0;
        if (who == OWN_PLUS)
            return (c == CHAR_T) ? MODE_STICKY : '0;
        case (c)
            CHAR_R:  grant = 12'o4;
            CHAR_W:  grant = 12'o2;
            CHAR_X:  grant = 12'o1;
            default: grant = '0;
        endcase
        if (who == OWN_USER)
            grant = grant << 6;
        else if (who == OWN_GROUP)
            grant = grant << 3;
        if (c == CHAR_S)
            grant = (who == OWN_USER) ? MODE_SETUID :
                    (who == OWN_GROUP) ? MODE_SETGID : '0;
        return grant;
    endfunction

    function automatic void clear_parse();
        pred_pos   = POS_START;
        pred_owner = OWN_USER;
        pred_err   = ERR_NONE;
        pred_mode  = '0;
    endfunction

    function automatic void parse_expected(input logic [CharWidth-1:0] c, input logic last);
        logic [ModeWidth-1:0] grant;
        mode_result_t         outcome;
        if (pred_err == ERR_NONE)
        begin
            case (pred_pos)
                POS_START:
                begin
                    if (c == CHAR_U)
                    begin
                        pred_owner = OWN_USER;
                        pred_pos   = POS_OWNER;
                    end
                    else if (c == CHAR_G)
                    begin
                        pred_owner = OWN_GROUP;
                        pred_pos   = POS_OWNER;
                    end
                    else if (c == CHAR_O)
                    begin
                        pred_owner = OWN_OTHER;
                        pred_pos   = POS_OWNER;
                    end
                    else if (c == CHAR_PLUS)
                    begin
                        pred_owner = OWN_PLUS;
                        pred_pos   = POS_OWNER;
                    end
                    else if (c != CHAR_COMMA)
                        pred_pos = POS_BADOWNER;
                end
                POS_OWNER:
                begin
                    if (c == CHAR_COMMA)
                        pred_err = ERR_MALFORMED;
                    else if (pred_owner == OWN_PLUS)
                    begin
                        grant = perm_bit(pred_owner, c);
                        if (grant == '0)
                            pred_err = ERR_PERMISSION;
                        else
                        begin
                            pred_mode = pred_mode | grant;
                            pred_pos  = POS_LETTERS;
                        end
                    end
                    else if (c == CHAR_EQUALS)
                        pred_pos = POS_LETTERS;
                    else
                        pred_err = ERR_MALFORMED;
                end
                POS_LETTERS:
                begin
                    if (c == CHAR_COMMA)
                        pred_pos = POS_START;
                    else
                    begin
                        grant = perm_bit(pred_owner, c);
                        if (grant == '0)
                            pred_err = ERR_PERMISSION;
                        else
                            pred_mode = pred_mode | grant;
                    end
                end
                default:
                    pred_err = (c == CHAR_EQUALS) ? ERR_OWNER : ERR_MALFORMED;
            endcase
        end
        if (last)
        begin
            if (pred_err == ERR_NONE && (pred_pos == POS_OWNER || pred_pos == POS_BADOWNER))
                pred_err = ERR_MALFORMED;
            outcome.mode = (pred_err == ERR_NONE) ? pred_mode : '0;
            outcome.err  = pred_err;
            expected_modes.push_back(outcome);
            err_tally[pred_err]++;
            clear_parse();
        end
    endfunction

    function automatic void flag_mismatch(input string what);
        fail_count++;
        if (fail_count <= ReportLimit)
            $display("Mismatch at cycle %0d: %s", cycle_count, what);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_modes.size() == 0)
                flag_mismatch($sformatf("unexpected item mode %o err %0d",
                                        res.mode_bits, res.error_code));
            else
            begin
                oldest = expected_modes.pop_front();
                results_seen++;
                if (res.mode_bits !== oldest.mode)
                    flag_mismatch($sformatf("mode expected %o actual %o",
                                            oldest.mode, res.mode_bits));
                if (res.error_code !== oldest.err)
                    flag_mismatch($sformatf("error expected %0d actual %0d",
                                            oldest.err, res.error_code));
            end
        end
    end

    initial
    begin
        int stall_left;
        int stall_style;
        int phase;
        stall_left  = 0;
        stall_style = 0;
        phase       = 0;
        res.ready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(30, 150);
            end
            case (stall_style)
                0:       res.ready = 1'b1;
                1:       res.ready = 1'($urandom_range(0, 1));
                2:       res.ready = (phase % 5) >= 2;
                default: res.ready = ($urandom_range(0, 7) == 0);
            endcase
            phase++;
            stall_left--;
        end
    end

    task automatic send_char(input logic [CharWidth-1:0] c, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 9) < 3)
            begin
                gap        = 0;
                burst_left = $urandom_range(20, 40);
            end
            else
            begin
                gap        = $urandom_range(1, 5);
                burst_left = $urandom_range(1, 12);
            end
            repeat (gap)
            begin
                @(negedge clk);
                chr.valid = 1'b0;
            end
        end
        @(negedge clk);
        chr.valid         = 1'b1;
        chr.char_code     = c;
        chr.end_of_string = last;
        @(posedge clk);
        while (!chr.ready)
            @(posedge clk);
        parse_expected(c, last);
        burst_left--;
        chars_sent++;
    endtask

    task automatic send_chars(input char_q_t s);
        for (int k = 0; k < s.size(); k++)
            send_char(s[k], k == s.size() - 1);
        strings_sent++;
    endtask

    task automatic send_text(input string text);
        char_q_t s;
        for (int k = 0; k < text.len(); k++)
            s.push_back(text[k]);
        send_chars(s);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        chr.valid = 1'b0;
        while (expected_modes.size() != 0)
            @(posedge clk);
    endtask

    function automatic char_q_t make_clause_string();
        char_q_t              s;
        int                   n_clauses;
        int                   n_letters;
        logic [CharWidth-1:0] owner_c;
        n_clauses = $urandom_range(1, 4);
        for (int k = 0; k < n_clauses; k++)
        begin
            if (k > 0)
                s.push_back(CHAR_COMMA);
            if ($urandom_range(0, 7) == 0)
                s.push_back(CHAR_COMMA);
            case ($urandom_range(0, 3))
                0:       owner_c = CHAR_U;
                1:       owner_c = CHAR_G;
                2:       owner_c = CHAR_O;
                default: owner_c = CHAR_PLUS;
            endcase
            s.push_back(owner_c);
            if (owner_c == CHAR_PLUS)
                n_letters = $urandom_range(1, 3);
            else
            begin
                s.push_back(CHAR_EQUALS);
                n_letters = $urandom_range(0, 4);
            end
            for (int j = 0; j < n_letters; j++)
            begin
                if (owner_c == CHAR_PLUS)
                    s.push_back(CHAR_T);
                else
                begin
                    case ($urandom_range(0, (owner_c == CHAR_O) ? 2 : 3))
                        0:       s.push_back(CHAR_R);
                        1:       s.push_back(CHAR_W);
                        2:       s.push_back(CHAR_X);
                        default: s.push_back(CHAR_S);
                    endcase
                end
            end
        end
        if ($urandom_range(0, 7) == 0)
            s.push_back(CHAR_COMMA);
        return s;
    endfunction

    task automatic test_well_formed();
        send_text(",u=rwxs,,g=rwxs,o=rwx,+t,");
        send_text("u=");
        send_text(",");
        send_text("+tt");
    endtask

    task automatic test_error_cases();
        char_q_t s;
        send_text("u");
        send_text("ux");
        send_text("g,");
        send_text("o=s");
        send_text("+=");
        send_text("+");
        send_text("u=q,g=r");
        send_text("a");
        s.push_back(8'hFF);
        s.push_back(CHAR_EQUALS);
        send_chars(s);
        s.delete();
        s.push_back(8'h00);
        s.push_back(CHAR_R);
        send_chars(s);
    endtask

    task automatic test_random_strings(input int char_budget);
        char_q_t s;
        int      start;
        int      kind;
        int      idx;
        start = chars_sent;
        while (chars_sent - start < char_budget)
        begin
            s    = make_clause_string();
            kind = $urandom_range(0, 9);
            if (kind == 6 || kind == 7)
            begin
                idx = $urandom_range(0, s.size() - 1);
                case ($urandom_range(0, 4))
                    0:       s[idx] = CharWidth'($urandom_range(0, 255));
                    1:       s[idx] = CHAR_S;
                    2:       s[idx] = CHAR_EQUALS;
                    3:       s[idx] = CHAR_COMMA;
                    default: s[idx] = CharWidth'($urandom_range(8'h61, 8'h7A));
                endcase
            end
            else if (kind == 8)
                s = s[0:$urandom_range(0, s.size() - 1)];
            else if (kind == 9)
            begin
                s.delete();
                repeat ($urandom_range(1, 6))
                    s.push_back(CharWidth'($urandom_range(0, 255)));
            end
            send_chars(s);
            if ($urandom_range(0, 49) == 0)
                wait_for_results();
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        chr.valid         = 1'b0;
        chr.char_code     = '0;
        chr.end_of_string = 1'b0;
        clear_parse();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_well_formed();
        wait_for_results();
        test_error_cases();
        wait_for_results();
        test_random_strings(RandomChars);
        wait_for_results();
        repeat (6) @(posedge clk);

        $display("Covered %0d strings in %0d characters, %0d results checked",
                 strings_sent, chars_sent, results_seen);
        $display("Outcomes: %0d clean, %0d malformed, %0d bad letter, %0d bad owner",
                 err_tally[ERR_NONE], err_tally[ERR_MALFORMED],
                 err_tally[ERR_PERMISSION], err_tally[ERR_OWNER]);
        if (fail_count == 0 && expected_modes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
